>>> hdl/gradient_noise_2d_defines.svh
// ----------------------------------------------------------------------------
// Gradient noise 2D assertion macros
// Shared concurrent assertion forms, one disabled while reset is high and one that also checks in reset.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_DEFINES_SVH
`define GRADIENT_NOISE_2D_DEFINES_SVH

// assert a property on every rising clock edge outside reset
`define GN2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assert a property on every rising clock edge, reset included
`define GN2_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/gn2_pkg.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D package
// Fixed-point formats, hash constants and gradient selection.
// ----------------------------------------------------------------------------
package gn2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 16;
  localparam int OUT_FRAC  = 16;
  localparam int OUT_W     = 18;

  localparam logic [31:0] HASH_MX = 32'd374761393;
  localparam logic [31:0] HASH_MY = 32'd668265263;
  localparam logic [31:0] HASH_MS = 32'd1274126177;

  localparam int GW = FRAC_BITS + 3;

  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_PN = 2'd2;
  localparam logic [1:0] GRAD_NN = 2'd3;

  typedef logic signed [GW-1:0] grad_t;

  function automatic grad_t grad(input logic [1:0] h, input grad_t dx, input grad_t dy);
    grad_t g;
    unique case (h)
      GRAD_PP: g = dx + dy;
      GRAD_NP: g = dy - dx;
      GRAD_PN: g = dx - dy;
      GRAD_NN: g = -dx - dy;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> hdl/gn2_hash.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D corner hash
// Three-stage multiply-xor hash of the four lattice corners of a point.
// ----------------------------------------------------------------------------
module gn2_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] noise_seed,
  output logic [1:0]  h [4]
);
  import gn2_pkg::*;

  logic signed [31:0] flx, fly;
  logic [31:0] cx, cy, cx1, cy1;
  logic [31:0] px0, px1, py0, py1, ps;
  logic [31:0] n [4];
  logic [31:0] m [4];

  always_comb begin
    flx = $signed(coord_x) >>> FRAC_BITS;
    fly = $signed(coord_y) >>> FRAC_BITS;
    cx  = {{(32-INT_BITS){flx[INT_BITS-1]}}, flx[INT_BITS-1:0]};
    cy  = {{(32-INT_BITS){fly[INT_BITS-1]}}, fly[INT_BITS-1:0]};
    cx1 = cx + 32'd1;
    cy1 = cy + 32'd1;
    n[0] = px0 ^ py0 ^ ps;
    n[1] = px1 ^ py0 ^ ps;
    n[2] = px0 ^ py1 ^ ps;
    n[3] = px1 ^ py1 ^ ps;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0 <= 32'(cx * HASH_MX);
      px1 <= 32'(cx1 * HASH_MX);
      py0 <= 32'(cy * HASH_MY);
      py1 <= 32'(cy1 * HASH_MY);
      ps  <= 32'(noise_seed * HASH_MS);
      for (int c = 0; c < 4; c++) begin
        m[c] <= 32'((n[c] ^ (n[c] >> 13)) * HASH_MS);
        h[c] <= m[c][1:0] ^ m[c][17:16];
      end
    end
  end

endmodule

>>> hdl/gn2_fade.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D fade curve
// Five-stage quintic fade 6t^5 - 15t^4 + 10t^3 of the coordinate fraction.
// ----------------------------------------------------------------------------
module gn2_fade (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              coord,
  output logic [gn2_pkg::FRAC_BITS:0] u
);
  import gn2_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [2*F+4:0] HALF = (2*F+5)'(1) << (F-1);
  localparam logic [F:0]     ONE  = (F+1)'(1) << F;

  logic [F-1:0]   t1, t2q;
  logic [2*F-1:0] tt;
  logic [F:0]     t2c;
  logic [2*F:0]   t3p;
  logic [F+3:0]   p;
  logic signed [F+6:0] ps;
  logic [2*F+4:0] fprod, fsum;
  logic [F:0]     t3;

  always_comb begin
    t2c  = (F+1)'(({1'b0, tt} + HALF[2*F:0]) >> F);
    ps   = (F+7)'(6 * $signed({6'b0, t2c}) - 15 * $signed({7'b0, t2q})
                  + $signed((F+7)'(10) << F));
    t3   = (F+1)'(({1'b0, t3p} + HALF[2*F+1:0]) >> F);
    fsum = (fprod + HALF) >> F;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= coord[F-1:0];
      tt    <= t1 * t1;
      t2q   <= t1;
      t3p   <= t2c * t2q;
      p     <= ps[F+6] ? '0 : ps[F+3:0];
      fprod <= (2*F+5)'(t3 * p);
      u     <= (fsum > (2*F+5)'(ONE)) ? ONE : fsum[F:0];
    end
  end

endmodule

>>> hdl/gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D
// Fixed-point 2D gradient noise of a Q16.16 point under a 32-bit seed.
// ----------------------------------------------------------------------------
// One point enters per cycle unless the output stalls; the pipeline depth is
// set by the fade curve's chain of three multiplies followed
// by two interpolation multiplies, each in a register stage of its own. The
// whole pipeline holds while a finished value waits at the output.
module gradient_noise_2d (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // coord_x, coord_y, noise_seed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // noise_value, zero fill
);
  import gn2_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SH   = F + 1 - OUT_FRAC;
  localparam int SH_R = (SH > 0) ? SH : 0;
  localparam int SH_L = (SH < 0) ? -SH : 0;
  localparam logic signed [39:0] RND   = (40'sd1 <<< SH_R) >>> 1;
  localparam logic signed [39:0] O_MIN = -40'sd32768;
  localparam logic signed [39:0] O_MAX = 40'sd98304;
  localparam logic signed [2*F+7:0] HALF = (2*F+8)'(1) <<< (F-1);

  logic       en;
  logic [9:1] vld;
  logic [1:0] h [4];
  logic [F:0] u, v, v6, v7;
  logic [F-1:0] fx1, fx2, fx3, fy1, fy2, fy3;
  grad_t dx0, dx1, dy0, dy1;
  grad_t g [4];
  logic signed [F+3:0] a0, a2, a0_6, a2_6, d1, d2, x1, x1_7, x1_8, x2;
  logic signed [2*F+5:0] p1, p2;
  logic signed [F+4:0] dd;
  logic signed [2*F+6:0] pv;
  logic signed [F+5:0] val, w;
  logic signed [39:0] wx, r;
  logic [OUT_W-1:0] value;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[9];
  assign m_tdata  = {{(24-OUT_W){1'b0}}, value};

  gn2_hash u_hash (
    .clk(clk), .en(en),
    .coord_x(s_tdata[31:0]), .coord_y(s_tdata[63:32]), .noise_seed(s_tdata[95:64]),
    .h(h)
  );

  gn2_fade u_fade_x (.clk(clk), .en(en), .coord(s_tdata[31:0]),  .u(u));
  gn2_fade u_fade_y (.clk(clk), .en(en), .coord(s_tdata[63:32]), .u(v));

  always_comb begin
    dx0 = $signed({3'b0, fx3});
    dy0 = $signed({3'b0, fy3});
    dx1 = dx0 - $signed(GW'(1) << F);
    dy1 = dy0 - $signed(GW'(1) << F);
    x1  = a0_6 + (F+4)'((p1 + (2*F+6)'(HALF)) >>> F);
    x2  = a2_6 + (F+4)'((p2 + (2*F+6)'(HALF)) >>> F);
    val = (F+6)'(x1_8) + (F+6)'((pv + (2*F+7)'(HALF)) >>> F);
    w   = val + $signed((F+6)'(1) << F);
    wx  = 40'(w);
    r   = (SH >= 0) ? ((wx + RND) >>> SH_R) : (wx <<< SH_L);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx1  <= s_tdata[F-1:0];
      fy1  <= s_tdata[32+F-1:32];
      fx2  <= fx1;
      fy2  <= fy1;
      fx3  <= fx2;
      fy3  <= fy2;
      g[0] <= grad(h[0], dx0, dy0);
      g[1] <= grad(h[1], dx1, dy0);
      g[2] <= grad(h[2], dx0, dy1);
      g[3] <= grad(h[3], dx1, dy1);
      a0   <= (F+4)'(g[0]);
      a2   <= (F+4)'(g[2]);
      d1   <= (F+4)'(g[1]) - (F+4)'(g[0]);
      d2   <= (F+4)'(g[3]) - (F+4)'(g[2]);
      a0_6 <= a0;
      a2_6 <= a2;
      p1   <= $signed({1'b0, u}) * d1;
      p2   <= $signed({1'b0, u}) * d2;
      v6   <= v;
      v7   <= v6;
      x1_7 <= x1;
      x1_8 <= x1_7;
      dd   <= (F+5)'(x2) - (F+5)'(x1);
      pv   <= $signed({1'b0, v7}) * dd;
      if (r < O_MIN) begin
        value <= OUT_W'(O_MIN);
      end else if (r > O_MAX) begin
        value <= OUT_W'(O_MAX);
      end else begin
        value <= r[OUT_W-1:0];
      end
    end
  end

endmodule

>>> hdl/gn2_checker.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D port checker
// Port-level checks of the noise pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_defines.svh"

module gn2_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [95:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  `GN2_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `GN2_ASSERT(a_range, m_tvalid |-> ($signed(m_tdata[17:0]) >= -18'sd32768) && ($signed(m_tdata[17:0]) <= 18'sd98304) && (m_tdata[23:18] == 6'd0), "noise value out of range")
  `GN2_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "result after reset")
  `GN2_ASSERT(a_ready_free, !m_tvalid |-> s_tready, "request refused with empty output")

  logic unused;
  assign unused = s_tvalid ^ (^s_tdata);

endmodule

bind gradient_noise_2d gn2_checker u_gn2_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> tb/gradient_noise_2d_tb.sv
// ----------------------------------------------------------------------------
// Gradient noise 2D testbench
// Drives points and seeds through the stream input, predicts each noise value
// in fixed point and compares it with the stream output in order.
// ----------------------------------------------------------------------------
module gradient_noise_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gn2_pkg::*;

  localparam int  RAND_POINTS = 1130;
  localparam int  LATENCY     = 9;
  localparam int  TABLE_ROWS  = 20;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] seed;
    bit          known;
    logic [17:0] value;
  } point_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  logic [17:0] noise_q[$];
  int          errors;
  longint      cycles;
  bit          quiet;
  bit          hold_sink;
  int          sink_gap;

  gradient_noise_2d u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [1:0] corner_bits(logic [31:0] ix, logic [31:0] iy,
                                             logic [31:0] sd);
    logic [31:0] n;
    n = (ix * HASH_MX) ^ (iy * HASH_MY) ^ (sd * HASH_MS);
    n = (n ^ (n >> 13)) * HASH_MS;
    n = n ^ (n >> 16);
    return n[1:0];
  endfunction

  function automatic longint fade_curve(longint t);
    longint one, half, t2, t3, p, f;
    one  = longint'(1) << FRAC_BITS;
    half = longint'(1) << (FRAC_BITS - 1);
    t2 = (t * t + half) >>> FRAC_BITS;
    t3 = (t2 * t + half) >>> FRAC_BITS;
    p = 6 * t2 - 15 * t + 10 * one;
    if (p < 0) p = 0;
    f = (t3 * p + half) >>> FRAC_BITS;
    if (f > one) f = one;
    return f;
  endfunction

  function automatic longint corner_dot(logic [1:0] h, longint dx, longint dy);
    case (h)
      GRAD_PP: return dx + dy;
      GRAD_NP: return dy - dx;
      GRAD_PN: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  function automatic longint blend(longint u, longint a, longint b);
    return a + rnd_shift(u * (b - a), FRAC_BITS);
  endfunction

  function automatic void split_axis(logic [31:0] raw, output logic [31:0] lat,
                                     output longint frac);
    longint c, fl, w;
    c  = longint'($signed(raw));
    fl = floor_div(c, FRAC_BITS);
    w  = fl & ((longint'(1) << INT_BITS) - 1);
    w  = (w ^ (longint'(1) << (INT_BITS - 1))) - (longint'(1) << (INT_BITS - 1));
    frac = c - fl * (longint'(1) << FRAC_BITS);
    lat = w[31:0];
  endfunction

  function automatic logic [17:0] noise_at(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] sd);
    logic [31:0] ix, iy, ix1, iy1;
    longint fx, fy, u, v, one, a, b, val, r;
    one = longint'(1) << FRAC_BITS;
    split_axis(px, ix, fx);
    split_axis(py, iy, fy);
    ix1 = ix + 32'd1;
    iy1 = iy + 32'd1;
    u = fade_curve(fx);
    v = fade_curve(fy);
    a = blend(u, corner_dot(corner_bits(ix, iy, sd), fx, fy),
              corner_dot(corner_bits(ix1, iy, sd), fx - one, fy));
    b = blend(u, corner_dot(corner_bits(ix, iy1, sd), fx, fy - one),
              corner_dot(corner_bits(ix1, iy1, sd), fx - one, fy - one));
    val = blend(v, a, b);
    r = rnd_shift(val + one, FRAC_BITS + 1 - OUT_FRAC);
    if (r < -32768) r = -32768;
    if (r > 98304) r = 98304;
    return r[17:0];
  endfunction

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] sd,
                            bit known, logic [17:0] value);
    logic [17:0] want;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sd, py, px};
    do @(posedge clk); while (!s_tready);
    want = noise_at(px, py, sd);
    if (known && want !== value) begin
      $error("table row: noise_value expected %0d actual %0d", $signed(value), $signed(want));
      errors++;
    end
    noise_q = {noise_q, (known ? value : want)};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 17);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (noise_q.size() == 0) begin
        $error("noise_value: no request waiting, actual %0d", $signed(m_tdata[17:0]));
        errors++;
      end else begin
        if (m_tdata[17:0] !== noise_q[0]) begin
          $error("noise_value: expected %0d actual %0d",
                 $signed(noise_q[0]), $signed(m_tdata[17:0]));
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gradient_noise_2d] ERROR");
      $finish;
    end
  end

  initial begin
    hold_sink = 1'b0;
    #200;
    @(posedge clk);
    hold_sink <= 1'b1;
    repeat (60) @(posedge clk);
    hold_sink <= 1'b0;
  end

  point_row_t rows [TABLE_ROWS];
  logic [31:0] px, py, sd;
  int sel;

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    // origin and integer lattice points give exactly one half
    rows[0]  = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 18'd32768};
    rows[1]  = '{32'h0001_0000, 32'h0003_0000, 32'hFFFF_FFFF, 1, 18'd32768};
    rows[2]  = '{32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 1, 18'd32768};
    rows[3]  = '{32'h7FFF_0000, 32'hFFFF_0000, 32'h0000_0001, 1, 18'd32768};
    rows[4]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 0, '0};
    rows[5]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, '0};
    rows[6]  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hA5A5_A5A5, 0, '0};
    rows[7]  = '{32'h0000_8000, 32'h0000_8000, 32'h0000_0000, 0, '0};
    rows[8]  = '{32'hFFFF_8000, 32'hFFFF_8000, 32'h5A5A_5A5A, 0, '0};
    rows[9]  = '{32'h0000_FFFF, 32'h0000_FFFF, 32'h8000_0000, 0, '0};
    rows[10] = '{32'h7FFF_8000, 32'h8000_8000, 32'h0000_0007, 0, '0};
    rows[11] = '{32'h1234_5678, 32'h9ABC_DEF0, 32'hDEAD_BEEF, 0, '0};
    for (int s = 0; s < 8; s++)
      rows[12 + s] = '{32'h0000_4000 + (s << 16), 32'h0000_C000, s, 0, '0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i])
      send_point(rows[i].cx, rows[i].cy, rows[i].seed, rows[i].known, rows[i].value);
    for (int n = 0; n < RAND_POINTS; n++) begin
      if (n == RAND_POINTS / 2) begin
        s_tvalid <= 1'b0;
        while (noise_q.size() != 0) @(posedge clk);
      end
      if (n == RAND_POINTS - 150) quiet = 1'b1;
      sel = $urandom_range(0, 3);
      px = $urandom();
      py = $urandom();
      sd = $urandom();
      if (sel == 0) begin
        px = $signed(16'($urandom())) * 32'sd4096 / 64;
        py = $signed(16'($urandom())) * 32'sd4096 / 64;
      end else if (sel == 1) begin
        px[31:16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      send_point(px, py, sd, 0, '0);
    end
    s_tvalid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[gradient_noise_2d] OK");
    end else begin
      $display("[gradient_noise_2d] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/gn2_pkg.sv
hdl/gn2_hash.sv
hdl/gn2_fade.sv
hdl/gradient_noise_2d.sv
hdl/gn2_checker.sv
tb/gradient_noise_2d_tb.sv
